### hw/rtl/sie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sie_pkg
// Shared types and constants of the sparse ILU entry update engine.
// ----------------------------------------------------------------------------
package sie_pkg;

	localparam int MAX_DIM     = 1024;
	localparam int MAX_ENTRIES = 4096;

	localparam int FUNC_W = 3;
	localparam int SLOT_W = 12;
	localparam int PTR_W  = 13;
	localparam int IDX_W  = 10;
	localparam int VAL_W  = 32;
	localparam int SUM_W  = 31;
	localparam int STAT_W = 2;

	localparam int PTR_AW = $clog2(MAX_DIM + 1);
	localparam int ENT_AW = $clog2(MAX_ENTRIES);
	localparam int ENT_W  = IDX_W + VAL_W;

	localparam int DIV_NW = VAL_W + 16;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	localparam logic [FUNC_W-1:0] F_LPTR = 3'd0;
	localparam logic [FUNC_W-1:0] F_LENT = 3'd1;
	localparam logic [FUNC_W-1:0] F_UPTR = 3'd2;
	localparam logic [FUNC_W-1:0] F_UENT = 3'd3;
	localparam logic [FUNC_W-1:0] F_UPD  = 3'd4;
	localparam logic [FUNC_W-1:0] F_RDL  = 3'd5;
	localparam logic [FUNC_W-1:0] F_RDU  = 3'd6;
	localparam logic [FUNC_W-1:0] F_CLR  = 3'd7;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_DIVZ = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVF  = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [SLOT_W-1:0]       slot;
		logic [PTR_W-1:0]        link;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [SUM_W-1:0]        squared_change;
		logic [SUM_W-1:0]        sweep_sum;
		logic [STAT_W-1:0]       status;
	} rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] val;
	} ent_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIV_NW-1:0] num;
		logic signed [VAL_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              neg;
		logic [DIV_NW-1:0] qmag;
	} div_rsp_t;

	function automatic logic ent_ok(input logic [PTR_W-1:0] p);
		return int'(p) < MAX_ENTRIES;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/sie_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sie_if
// Request and response channels of the entry update engine.
// ----------------------------------------------------------------------------
interface sie_req_if;
	logic          valid;
	logic          ready;
	sie_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface

interface sie_rsp_if;
	logic          valid;
	logic          ready;
	sie_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface
`default_nettype wire

### hw/rtl/sparse_ilu_entry_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_ilu_entry_update
// ILU(0) entry update engine over L (row-compressed) and U (column-compressed).
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (func, slot, link, row, col, value); rsp returns
//   exactly one response per request, in order. Both use valid/ready.
//   Pointer writes, entry writes and clear go straight to the response state;
//   reads first pass a RAM read state. An update reads two pointer pairs, then
//   walks the L row and U column, each merge step being entry RAM read,
//   compare/multiply and accumulate, then finishes (target read, write-back,
//   square, sum). Lower-factor targets with a nonzero divisor add a bit-serial
//   divide after the target read. The merge walk and the divider set how long
//   an update takes.
//   One request is in flight at a time; req.ready is high only when idle.
//   The response register holds a finished result while rsp is stalled; the
//   next request is accepted meanwhile, and its result waits until the
//   register frees. Reset clears the sweep sum and control state; factor
//   RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module sparse_ilu_entry_update (
	input  wire logic clk,
	input  wire logic arst_n,
	sie_req_if.sink   req,
	sie_rsp_if.source rsp
);
	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_PTR1 = 14'b00000000000010,
		S_PTR2 = 14'b00000000000100,
		S_LOOP = 14'b00000000001000,
		S_MEV  = 14'b00000000010000,
		S_MACC = 14'b00000000100000,
		S_FRD  = 14'b00000001000000,
		S_WAIT = 14'b00000010000000,
		S_FWR  = 14'b00000100000000,
		S_FMUL = 14'b00001000000000,
		S_FSUM = 14'b00010000000000,
		S_RD   = 14'b00100000000000,
		S_DONE = 14'b01000000000000,
		S_SPR  = 14'b10000000000000
	} st_t;

	localparam logic signed [63:0] Q_MAX64 = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] Q_MIN64 = -64'sh0000_0000_8000_0000;
	localparam logic signed [sie_pkg::VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [sie_pkg::VAL_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic [sie_pkg::SUM_W-1:0] SUM_MAX = '1;

	st_t state_q, state_d;

	logic                        lp_we, up_we;
	logic [sie_pkg::PTR_AW-1:0]  lp_addr, up_addr;
	logic [sie_pkg::PTR_W-1:0]   lp_wd, lp_rd, up_wd, up_rd;
	logic                        le_we, ue_we;
	logic [sie_pkg::ENT_AW-1:0]  le_addr, ue_addr;
	sie_pkg::ent_t               le_wd, le_rd, ue_wd, ue_rd;

	sie_pkg::req_t               r_q;
	logic [sie_pkg::PTR_W-1:0]   lp_q, lend_q, up_q, uend_q, tgt_q;
	logic signed [63:0]          acc_q, last_q, prod_q;
	logic                        match_q, lok_q, uok_q, tok_q, dok_q;
	logic signed [sie_pkg::VAL_W-1:0] sv_q, old_q, new_q;
	logic [sie_pkg::IDX_W-1:0]   oidx_q;
	logic                        ovf_q, divz_q;
	logic [sie_pkg::VAL_W:0]     mag_q;
	logic [sie_pkg::SUM_W-1:0]   sq_q, sum_q;
	sie_pkg::rsp_t               res_q, out_q;
	logic                        out_v_q;

	sie_pkg::div_req_t           div_rq;
	sie_pkg::div_rsp_t           div_rs;

	logic                        acc_in, lower, loop_go, out_load;
	logic signed [63:0]          total, prod_sh;
	logic signed [sie_pkg::VAL_W-1:0] lv, uv, dv;
	logic [sie_pkg::IDX_W-1:0]   lc, uc;
	logic [sie_pkg::PTR_W-1:0]   tgt_d;
	logic [sie_pkg::VAL_W:0]     diff;
	logic [47:0]                 sq_full;
	logic [sie_pkg::SUM_W:0]     sum_full;

	assign req.ready = state_q == S_IDLE;
	assign acc_in    = req.valid && req.ready;
	assign lower     = r_q.row > r_q.col;
	assign loop_go   = (lp_q < lend_q) && (up_q < uend_q);
	assign out_load  = (state_q == S_DONE) && (!out_v_q || rsp.ready);
	assign total     = acc_q + last_q;
	assign prod_sh   = prod_q >>> 16;
	assign lc        = lok_q ? le_rd.idx : '0;
	assign uc        = uok_q ? ue_rd.idx : '0;
	assign lv        = lok_q ? le_rd.val : '0;
	assign uv        = uok_q ? ue_rd.val : '0;
	assign dv        = dok_q ? ue_rd.val : '0;
	assign tgt_d     = lower ? lp_q - 1'b1 : up_q - 1'b1;
	assign diff      = {old_q[sie_pkg::VAL_W-1], old_q} - {new_q[sie_pkg::VAL_W-1], new_q};
	assign sq_full   = 48'(mag_q[23:0]) * 48'(mag_q[23:0]);
	assign sum_full  = {1'b0, sum_q} + {1'b0, sq_q};

	assign div_rq.start = (state_q == S_FRD) && lower && (dv != 0);
	assign div_rq.num   = sie_pkg::DIV_NW'(sv_q) <<< 16;
	assign div_rq.den   = dv;

	sie_div u_div (.clk(clk), .arst_n(arst_n), .rq(div_rq), .rs(div_rs));

	sie_ram #(.DEPTH(sie_pkg::MAX_DIM + 1), .WIDTH(sie_pkg::PTR_W)) u_lptr (
		.clk(clk), .we(lp_we), .addr(lp_addr), .wdata(lp_wd), .rdata(lp_rd));
	sie_ram #(.DEPTH(sie_pkg::MAX_DIM + 1), .WIDTH(sie_pkg::PTR_W)) u_uptr (
		.clk(clk), .we(up_we), .addr(up_addr), .wdata(up_wd), .rdata(up_rd));
	sie_ram #(.DEPTH(sie_pkg::MAX_ENTRIES), .WIDTH(sie_pkg::ENT_W)) u_lent (
		.clk(clk), .we(le_we), .addr(le_addr), .wdata(le_wd), .rdata(le_rd));
	sie_ram #(.DEPTH(sie_pkg::MAX_ENTRIES), .WIDTH(sie_pkg::ENT_W)) u_uent (
		.clk(clk), .we(ue_we), .addr(ue_addr), .wdata(ue_wd), .rdata(ue_rd));

	// memory port control
	always_comb begin
		lp_we   = 1'b0;
		up_we   = 1'b0;
		le_we   = 1'b0;
		ue_we   = 1'b0;
		lp_addr = '0;
		up_addr = '0;
		le_addr = '0;
		ue_addr = '0;
		lp_wd   = req.data.link;
		up_wd   = req.data.link;
		le_wd   = {req.data.link[sie_pkg::IDX_W-1:0], req.data.value};
		ue_wd   = {req.data.link[sie_pkg::IDX_W-1:0], req.data.value};
		unique case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					unique case (req.data.func)
						sie_pkg::F_LPTR: begin
							lp_we   = int'(req.data.slot) <= sie_pkg::MAX_DIM;
							lp_addr = sie_pkg::PTR_AW'(req.data.slot);
						end
						sie_pkg::F_UPTR: begin
							up_we   = int'(req.data.slot) <= sie_pkg::MAX_DIM;
							up_addr = sie_pkg::PTR_AW'(req.data.slot);
						end
						sie_pkg::F_LENT: begin
							le_we   = int'(req.data.slot) < sie_pkg::MAX_ENTRIES;
							le_addr = sie_pkg::ENT_AW'(req.data.slot);
						end
						sie_pkg::F_UENT: begin
							ue_we   = int'(req.data.slot) < sie_pkg::MAX_ENTRIES;
							ue_addr = sie_pkg::ENT_AW'(req.data.slot);
						end
						sie_pkg::F_UPD: begin
							lp_addr = sie_pkg::PTR_AW'(req.data.row);
							up_addr = sie_pkg::PTR_AW'(req.data.col);
						end
						sie_pkg::F_RDL: le_addr = sie_pkg::ENT_AW'(req.data.slot);
						sie_pkg::F_RDU: ue_addr = sie_pkg::ENT_AW'(req.data.slot);
						default: ;
					endcase
				end
			end
			S_PTR1: begin
				lp_addr = sie_pkg::PTR_AW'(r_q.row) + sie_pkg::PTR_AW'(1);
				up_addr = sie_pkg::PTR_AW'(r_q.col) + sie_pkg::PTR_AW'(1);
			end
			S_LOOP: begin
				if (loop_go) begin
					le_addr = sie_pkg::ENT_AW'(lp_q);
					ue_addr = sie_pkg::ENT_AW'(up_q);
				end else if (lower) begin
					le_addr = sie_pkg::ENT_AW'(tgt_d);
					ue_addr = sie_pkg::ENT_AW'(uend_q - 1'b1);
				end else begin
					ue_addr = sie_pkg::ENT_AW'(tgt_d);
				end
			end
			S_FWR: begin
				le_wd = {oidx_q, new_q};
				ue_wd = {oidx_q, new_q};
				if (lower) begin
					le_we   = tok_q;
					le_addr = sie_pkg::ENT_AW'(tgt_q);
				end else begin
					ue_we   = tok_q;
					ue_addr = sie_pkg::ENT_AW'(tgt_q);
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc_in) begin
					unique case (req.data.func)
						sie_pkg::F_UPD: state_d = S_PTR1;
						sie_pkg::F_RDL, sie_pkg::F_RDU: state_d = S_RD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_PTR1: state_d = S_PTR2;
			S_PTR2: state_d = S_LOOP;
			S_LOOP: state_d = loop_go ? S_MEV : S_FRD;
			S_MEV:  state_d = S_MACC;
			S_MACC: state_d = S_LOOP;
			S_FRD:  state_d = div_rq.start ? S_WAIT : S_FWR;
			S_WAIT: state_d = div_rs.done ? S_FWR : S_WAIT;
			S_FWR:  state_d = S_FMUL;
			S_FMUL: state_d = S_FSUM;
			S_FSUM: state_d = S_DONE;
			S_RD:   state_d = S_DONE;
			S_DONE: state_d = out_load ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (acc_in && req.data.func == sie_pkg::F_CLR) begin
				sum_q <= '0;
			end else if (state_q == S_FSUM) begin
				sum_q <= sum_full[sie_pkg::SUM_W] ? SUM_MAX : sum_full[sie_pkg::SUM_W-1:0];
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				r_q    <= req.data;
				acc_q  <= 64'(req.data.value);
				last_q <= '0;
				ovf_q  <= 1'b0;
				divz_q <= 1'b0;
				res_q  <= '{result_value: '0, squared_change: '0,
					sweep_sum: (req.data.func == sie_pkg::F_CLR) ? '0 : sum_q,
					status: sie_pkg::ST_OK};
			end
			S_PTR1: begin
				lp_q <= lp_rd;
				up_q <= up_rd;
			end
			S_PTR2: begin
				lend_q <= lp_rd;
				uend_q <= up_rd;
			end
			S_LOOP: begin
				lok_q <= sie_pkg::ent_ok(lp_q);
				uok_q <= sie_pkg::ent_ok(up_q);
				tgt_q <= tgt_d;
				tok_q <= sie_pkg::ent_ok(tgt_d);
				dok_q <= sie_pkg::ent_ok(uend_q - 1'b1);
				if (total > Q_MAX64) begin
					sv_q <= Q_MAX;
				end else if (total < Q_MIN64) begin
					sv_q <= Q_MIN;
				end else begin
					sv_q <= sie_pkg::VAL_W'(total);
				end
				if (!loop_go && (total > Q_MAX64 || total < Q_MIN64)) begin
					ovf_q <= 1'b1;
				end
			end
			S_MEV: begin
				prod_q  <= lv * uv;
				match_q <= lc == uc;
				if (lc <= uc) lp_q <= lp_q + 1'b1;
				if (lc >= uc) up_q <= up_q + 1'b1;
			end
			S_MACC: begin
				if (match_q) acc_q <= acc_q - prod_sh;
				last_q <= match_q ? prod_sh : '0;
			end
			S_FRD: begin
				old_q  <= !tok_q ? '0 : (lower ? le_rd.val : ue_rd.val);
				oidx_q <= lower ? le_rd.idx : ue_rd.idx;
				if (!lower) begin
					new_q <= sv_q;
				end else if (dv == 0) begin
					divz_q <= 1'b1;
					new_q  <= sv_q[sie_pkg::VAL_W-1] ? Q_MIN : Q_MAX;
				end
			end
			S_WAIT: begin
				if (div_rs.done) begin
					if (!div_rs.neg && div_rs.qmag > sie_pkg::DIV_NW'(Q_MAX)) begin
						new_q <= Q_MAX;
						ovf_q <= 1'b1;
					end else if (div_rs.neg &&
						div_rs.qmag > (sie_pkg::DIV_NW'(1) << (sie_pkg::VAL_W - 1))) begin
						new_q <= Q_MIN;
						ovf_q <= 1'b1;
					end else if (div_rs.neg) begin
						new_q <= 0 - sie_pkg::VAL_W'(div_rs.qmag);
					end else begin
						new_q <= sie_pkg::VAL_W'(div_rs.qmag);
					end
				end
			end
			S_FWR: mag_q <= diff[sie_pkg::VAL_W] ? 0 - diff : diff;
			S_FMUL: begin
				if (mag_q >= (33'd1 << 24) || sq_full[47:16] > 32'(SUM_MAX)) begin
					sq_q  <= SUM_MAX;
					ovf_q <= 1'b1;
				end else begin
					sq_q <= sq_full[16 +: sie_pkg::SUM_W];
				end
			end
			S_FSUM: begin
				res_q.result_value   <= new_q;
				res_q.squared_change <= sq_q;
				res_q.sweep_sum      <= sum_full[sie_pkg::SUM_W] ? SUM_MAX
					: sum_full[sie_pkg::SUM_W-1:0];
				res_q.status <= divz_q ? sie_pkg::ST_DIVZ
					: ((ovf_q || sum_full[sie_pkg::SUM_W]) ? sie_pkg::ST_OVF : sie_pkg::ST_OK);
			end
			S_RD: begin
				res_q.result_value <= (int'(r_q.slot) >= sie_pkg::MAX_ENTRIES) ? '0
					: ((r_q.func == sie_pkg::F_RDL) ? le_rd.val : ue_rd.val);
			end
			default: ;
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;
endmodule
`default_nettype wire

### hw/rtl/sie_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sie_ram
// Single-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module sie_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### hw/rtl/sie_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sie_div
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sie_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sie_pkg::div_req_t  rq,
	output sie_pkg::div_rsp_t       rs
);
	logic                            busy_q;
	logic                            done_q;
	logic [sie_pkg::DIV_CW-1:0]      cnt_q;
	logic [sie_pkg::DIV_NW-1:0]      n_q;
	logic [sie_pkg::VAL_W:0]         rem_q;
	logic [sie_pkg::VAL_W-1:0]       d_q;
	logic                            neg_q;
	logic [sie_pkg::VAL_W:0]         rem_sh;
	logic                            fits;

	assign rem_sh = {rem_q[sie_pkg::VAL_W-1:0], n_q[sie_pkg::DIV_NW-1]};
	assign fits   = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (rq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= sie_pkg::DIV_CW'(sie_pkg::DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == sie_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rq.start) begin
			n_q   <= rq.num[sie_pkg::DIV_NW-1] ? 0 - rq.num : rq.num;
			d_q   <= rq.den[sie_pkg::VAL_W-1] ? 0 - rq.den : rq.den;
			neg_q <= rq.num[sie_pkg::DIV_NW-1] ^ rq.den[sie_pkg::VAL_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, d_q} : rem_sh;
			n_q   <= {n_q[sie_pkg::DIV_NW-2:0], fits};
		end
	end

	assign rs.done = done_q;
	assign rs.neg  = neg_q;
	assign rs.qmag = n_q;
endmodule
`default_nettype wire

### hw/rtl/sie_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sie_chk
// Port-level checks of the entry update engine, bound to the top level.
// ----------------------------------------------------------------------------
module sie_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire sie_pkg::req_t req_data,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire sie_pkg::rsp_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped or changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status != sie_pkg::ST_BAD)
		else $error("undefined status code");

	a_sum_covers_sq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.sweep_sum >= rsp_data.squared_change)
		else $error("sweep sum below squared change");

	a_clear_resp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.func == sie_pkg::F_CLR && !rsp_valid
		|-> ##2 rsp_valid && rsp_data.sweep_sum == 0)
		else $error("clear response missing or sum not zero");
endmodule

bind sparse_ilu_entry_update sie_chk u_sie_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sparse ILU entry update engine. Loads small
// banded L and U factors, runs directed edge requests, then random traffic
// under three sender/receiver idling mixes. A built-in predictor tracks
// factor contents and sweep sum; every response is checked in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int WALK_MAX = 64;
	localparam longint Q_HI = 64'sd2147483647;
	localparam longint Q_LO = -64'sd2147483648;
	localparam longint SUM_HI = 64'sd2147483647;

	logic clk;
	logic arst_n;

	sie_req_if req_ch();
	sie_rsp_if rsp_ch();

	sparse_ilu_entry_update uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	logic [sie_pkg::PTR_W-1:0] lrow_ptr [0:sie_pkg::MAX_DIM];
	logic [sie_pkg::PTR_W-1:0] ucol_ptr [0:sie_pkg::MAX_DIM];
	bit lrow_ptr_set [0:sie_pkg::MAX_DIM];
	bit ucol_ptr_set [0:sie_pkg::MAX_DIM];
	logic [sie_pkg::IDX_W-1:0] l_col [0:sie_pkg::MAX_ENTRIES-1];
	logic [sie_pkg::IDX_W-1:0] u_row [0:sie_pkg::MAX_ENTRIES-1];
	longint l_val [0:sie_pkg::MAX_ENTRIES-1];
	longint u_val [0:sie_pkg::MAX_ENTRIES-1];
	bit l_set [0:sie_pkg::MAX_ENTRIES-1];
	bit u_set [0:sie_pkg::MAX_ENTRIES-1];
	longint change_sum;

	sie_pkg::rsp_t pending_rsp[$];
	int errors;
	int mismatches;
	int tx_idle;
	int rx_idle;

	always #6 clk = ~clk;

	initial begin
		#40ms;
		$display("tb: failure");
		$finish;
	end

	function automatic longint sat32(input longint v, inout bit ovf);
		if (v > Q_HI) begin
			ovf = 1;
			return Q_HI;
		end
		if (v < Q_LO) begin
			ovf = 1;
			return Q_LO;
		end
		return v;
	endfunction

	function automatic bit l_ok(input logic [sie_pkg::PTR_W-1:0] p);
		return p >= sie_pkg::MAX_ENTRIES || l_set[p];
	endfunction

	function automatic bit u_ok(input logic [sie_pkg::PTR_W-1:0] p);
		return p >= sie_pkg::MAX_ENTRIES || u_set[p];
	endfunction

	function automatic longint l_rd(input logic [sie_pkg::PTR_W-1:0] p);
		return p < sie_pkg::MAX_ENTRIES ? l_val[p] : 0;
	endfunction

	function automatic longint u_rd(input logic [sie_pkg::PTR_W-1:0] p);
		return p < sie_pkg::MAX_ENTRIES ? u_val[p] : 0;
	endfunction

	// returns 0 if the update would touch unwritten storage or walk too far
	function automatic bit entry_update(input sie_pkg::req_t r, input bit commit,
			output sie_pkg::rsp_t o);
		logic [sie_pkg::PTR_W-1:0] lp, lend, up, uend, tgt, dpos;
		logic [sie_pkg::IDX_W-1:0] lc, uc;
		longint acc, last, sv, newv, oldv, d, diff, mag, sq;
		bit ovf, divz, ok;
		int steps;
		o = '0;
		ovf = 0;
		divz = 0;
		steps = 0;
		ok = lrow_ptr_set[r.row] && lrow_ptr_set[int'(r.row) + 1] &&
			ucol_ptr_set[r.col] && ucol_ptr_set[int'(r.col) + 1];
		if (!ok)
			return 0;
		lp = lrow_ptr[r.row];
		lend = lrow_ptr[int'(r.row) + 1];
		up = ucol_ptr[r.col];
		uend = ucol_ptr[int'(r.col) + 1];
		acc = longint'(r.value);
		last = 0;
		while (lp < lend && up < uend) begin
			steps++;
			if (steps > WALK_MAX || !l_ok(lp) || !u_ok(up))
				return 0;
			lc = lp < sie_pkg::MAX_ENTRIES ? l_col[lp] : '0;
			uc = up < sie_pkg::MAX_ENTRIES ? u_row[up] : '0;
			last = 0;
			if (lc == uc) begin
				last = (l_rd(lp) * u_rd(up)) >>> 16;
				acc -= last;
			end
			if (lc <= uc)
				lp++;
			if (lc >= uc)
				up++;
		end
		acc += last;
		sv = sat32(acc, ovf);
		if (r.row > r.col) begin
			dpos = uend - 1'b1;
			tgt = lp - 1'b1;
			if (!u_ok(dpos) || !l_ok(tgt))
				return 0;
			d = u_rd(dpos);
			if (d == 0) begin
				divz = 1;
				newv = sv < 0 ? Q_LO : Q_HI;
			end else begin
				newv = sat32((sv * 65536) / d, ovf);
			end
			oldv = l_rd(tgt);
			if (commit && tgt < sie_pkg::MAX_ENTRIES)
				l_val[tgt] = newv;
		end else begin
			newv = sv;
			tgt = up - 1'b1;
			if (!u_ok(tgt))
				return 0;
			oldv = u_rd(tgt);
			if (commit && tgt < sie_pkg::MAX_ENTRIES)
				u_val[tgt] = newv;
		end
		diff = oldv - newv;
		mag = diff < 0 ? -diff : diff;
		if (mag >= (64'sd1 << 24)) begin
			sq = SUM_HI;
			ovf = 1;
		end else begin
			sq = (mag * mag) >>> 16;
			if (sq > SUM_HI) begin
				sq = SUM_HI;
				ovf = 1;
			end
		end
		if (commit) begin
			change_sum += sq;
			if (change_sum > SUM_HI) begin
				change_sum = SUM_HI;
				ovf = 1;
			end
		end
		o.result_value = newv[31:0];
		o.squared_change = sq[30:0];
		o.status = divz ? sie_pkg::ST_DIVZ : (ovf ? sie_pkg::ST_OVF : sie_pkg::ST_OK);
		return 1;
	endfunction

	function automatic sie_pkg::rsp_t predict_rsp(input sie_pkg::req_t r);
		sie_pkg::rsp_t o;
		o = '0;
		case (r.func)
			sie_pkg::F_LPTR: begin
				if (r.slot <= sie_pkg::MAX_DIM) begin
					lrow_ptr[r.slot] = r.link;
					lrow_ptr_set[r.slot] = 1;
				end
			end
			sie_pkg::F_UPTR: begin
				if (r.slot <= sie_pkg::MAX_DIM) begin
					ucol_ptr[r.slot] = r.link;
					ucol_ptr_set[r.slot] = 1;
				end
			end
			sie_pkg::F_LENT: begin
				l_col[r.slot] = r.link[sie_pkg::IDX_W-1:0];
				l_val[r.slot] = longint'(r.value);
				l_set[r.slot] = 1;
			end
			sie_pkg::F_UENT: begin
				u_row[r.slot] = r.link[sie_pkg::IDX_W-1:0];
				u_val[r.slot] = longint'(r.value);
				u_set[r.slot] = 1;
			end
			sie_pkg::F_UPD: void'(entry_update(r, 1, o));
			sie_pkg::F_RDL: o.result_value = l_val[r.slot][31:0];
			sie_pkg::F_RDU: o.result_value = u_val[r.slot][31:0];
			default: change_sum = 0;
		endcase
		o.sweep_sum = change_sum[30:0];
		return o;
	endfunction

	function automatic sie_pkg::req_t mk(input logic [sie_pkg::FUNC_W-1:0] f, input int slot,
			input int link, input int row, input int col, input logic [31:0] v);
		sie_pkg::req_t r;
		r.func = f;
		r.slot = sie_pkg::SLOT_W'(slot);
		r.link = sie_pkg::PTR_W'(link);
		r.row = sie_pkg::IDX_W'(row);
		r.col = sie_pkg::IDX_W'(col);
		r.value = v;
		return r;
	endfunction

	function automatic logic [31:0] rand_val();
		int k;
		k = $urandom_range(0, 9);
		if (k < 7)
			return $urandom_range(0, 2**18) - 2**17;
		if (k == 7)
			return $urandom;
		if (k == 8)
			return 0;
		return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
	endfunction

	function automatic int pick_index();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5)
			return $urandom_range(0, 11);
		if (k < 9)
			return $urandom_range(1015, 1023);
		return $urandom_range(0, 1023);
	endfunction

	task automatic send(input sie_pkg::req_t r);
		if ($urandom_range(0, 99) < tx_idle) begin
			req_ch.valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		pending_rsp.push_back(predict_rsp(r));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 0;
		end else begin
			rsp_ch.ready <= $urandom_range(0, 99) >= rx_idle;
		end
	end

	always @(posedge clk) begin
		sie_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("unexpected response %h", rsp_ch.data);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.data.result_value !== want.result_value ||
						rsp_ch.data.squared_change !== want.squared_change ||
						rsp_ch.data.sweep_sum !== want.sweep_sum ||
						rsp_ch.data.status !== want.status) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp val %h sq %h sum %h st %0d,",
							" got val %h sq %h sum %h st %0d"},
							want.result_value, want.squared_change, want.sweep_sum,
							want.status, rsp_ch.data.result_value,
							rsp_ch.data.squared_change, rsp_ch.data.sweep_sum,
							rsp_ch.data.status);
				end
			end
		end
	end

	// banded factors: pointer slots 0..11 and 1016..1024, entries 0..63
	task automatic test_load_factors();
		int e, q;
		for (int k = 0; k <= 11; k++) begin
			send(mk(sie_pkg::F_LPTR, k, k == 0 ? 0 : 4 * (k - 1), 0, 0, 0));
			send(mk(sie_pkg::F_UPTR, k, k == 0 ? 0 : 4 * (k - 1), 0, 0, 0));
		end
		for (int j = 0; j <= 8; j++) begin
			send(mk(sie_pkg::F_LPTR, 1016 + j, 40 + 3 * j, 0, 0, 0));
			send(mk(sie_pkg::F_UPTR, 1016 + j, 40 + 3 * j, 0, 0, 0));
		end
		for (e = 0; e < 64; e++) begin
			q = e < 40 ? e % 4 : (e - 40) % 3;
			send(mk(sie_pkg::F_LENT, e, 2 * q + $urandom_range(0, 1), 0, 0, rand_val()));
			send(mk(sie_pkg::F_UENT, e, 2 * q + $urandom_range(0, 1), 0, 0, rand_val()));
		end
	endtask

	task automatic test_directed();
		send(mk(sie_pkg::F_LPTR, 4095, 4096, 0, 0, 0));
		send(mk(sie_pkg::F_UPTR, 2000, 4095, 0, 0, 0));
		send(mk(sie_pkg::F_LENT, 4095, 4095, 0, 0, 32'h8000_0000));
		send(mk(sie_pkg::F_UENT, 4095, 4096, 0, 0, 32'h7fff_ffff));
		send(mk(sie_pkg::F_RDL, 4095, 0, 0, 0, 0));
		send(mk(sie_pkg::F_RDU, 4095, 0, 0, 0, 0));
		send(mk(sie_pkg::F_RDL, 0, 0, 0, 0, 0));
		send(mk(sie_pkg::F_RDU, 63, 0, 0, 0, 0));
		// empty segments: target before segment, zero divisor
		send(mk(sie_pkg::F_UPD, 0, 0, 0, 0, 32'h0001_0000));
		send(mk(sie_pkg::F_UPD, 0, 0, 5, 0, 32'hffff_0000));
		send(mk(sie_pkg::F_UPD, 0, 0, 5, 0, 32'h0002_0000));
		send(mk(sie_pkg::F_UENT, 7, 1, 0, 0, 0));
		send(mk(sie_pkg::F_UPD, 0, 0, 3, 2, 32'h0000_8000));
		send(mk(sie_pkg::F_UPD, 0, 0, 1023, 1023, 32'h7fff_ffff));
		send(mk(sie_pkg::F_UPD, 0, 0, 1023, 1016, 32'h8000_0000));
		send(mk(sie_pkg::F_UPD, 0, 0, 3, 5, 32'h0003_0000));
		send(mk(sie_pkg::F_UPD, 0, 0, 7, 2, 32'hfffd_0000));
		send(mk(sie_pkg::F_CLR, 0, 0, 0, 0, 0));
		send(mk(sie_pkg::F_UPD, 0, 0, 1017, 1020, 32'h8000_0000));
		send(mk(sie_pkg::F_UPD, 0, 0, 9, 4, 32'h0000_0001));
		send(mk(sie_pkg::F_UENT, 7, 6, 0, 0, 32'h0000_4000));
	endtask

	task automatic test_random(input int count);
		sie_pkg::req_t r;
		sie_pkg::rsp_t scratch;
		int k, slot;
		bit found;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			slot = $urandom_range(0, 15) == 0 ? 4095 : $urandom_range(0, 63);
			if (k < 60) begin
				found = 0;
				for (int t = 0; t < 40 && !found; t++) begin
					r = mk(sie_pkg::F_UPD, 0, 0, pick_index(), pick_index(), rand_val());
					found = entry_update(r, 0, scratch);
				end
				if (!found)
					r = mk(sie_pkg::F_RDU, slot, 0, 0, 0, 0);
			end else if (k < 70) begin
				r = mk($urandom_range(0, 1) ? sie_pkg::F_RDL : sie_pkg::F_RDU, slot,
					0, 0, 0, 0);
			end else if (k < 84) begin
				r = mk($urandom_range(0, 1) ? sie_pkg::F_LENT : sie_pkg::F_UENT, slot,
					$urandom_range(0, 7) == 0 ? $urandom_range(0, 4096) : $urandom_range(0, 15),
					0, 0, rand_val());
			end else if (k < 94) begin
				if ($urandom_range(0, 3) == 0)
					slot = $urandom_range(sie_pkg::MAX_DIM + 1, 4095);
				else
					slot = $urandom_range(0, 1) ? $urandom_range(0, 11)
						: $urandom_range(1015, 1024);
				r = mk($urandom_range(0, 1) ? sie_pkg::F_LPTR : sie_pkg::F_UPTR, slot,
					$urandom_range(0, 9) == 0 ? 4096 : $urandom_range(0, 64), 0, 0, 0);
			end else begin
				r = mk(sie_pkg::F_CLR, 0, 0, 0, 0, 0);
			end
			r.row = r.func == sie_pkg::F_UPD ? r.row : sie_pkg::IDX_W'($urandom);
			r.col = r.func == sie_pkg::F_UPD ? r.col : sie_pkg::IDX_W'($urandom);
			send(r);
		end
	endtask

	task automatic test_idle_mixes();
		tx_idle = 10;
		rx_idle = 66;
		test_random(350);
		tx_idle = 66;
		rx_idle = 10;
		test_random(175);
		wait_drained();
		test_random(175);
		tx_idle = 0;
		rx_idle = 0;
		test_random(350);
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		req_ch.valid <= 0;
		req_ch.data <= '0;
		errors = 0;
		mismatches = 0;
		change_sum = 0;
		tx_idle = 10;
		rx_idle = 66;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_load_factors();
		test_directed();
		test_idle_mixes();
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/sie_pkg.sv
hw/rtl/sie_if.sv
hw/rtl/sie_ram.sv
hw/rtl/sie_div.sv
hw/rtl/sparse_ilu_entry_update.sv
hw/rtl/sie_chk.sv
sim/tb.sv
